// File: design/gbts_pkg.sv
package gbts_pkg;

    // store geometry
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 13;
    localparam int CHAR_W   = 16;

    localparam logic [POS_W-1:0] CAP_LEN = POS_W'(CAPACITY);

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_APPLY,
        S_READ_WAIT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic judge;
        logic read_rd;
        logic move_rd;
        logic move_wr;
        logic apply;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic check_fail;
        logic is_read;
        logic move_left;
        logic move_right;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/gbts_req_if.sv
interface gbts_req_if
    import gbts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    range_end;
    logic [CHAR_W-1:0]   char_in;

    modport source (output valid, output kind, output position, output range_end,
                    output char_in, input ready);
    modport sink   (input valid, input kind, input position, input range_end,
                    input char_in, output ready);
endinterface

// File: design/gbts_rsp_if.sv
interface gbts_rsp_if
    import gbts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   char_out;
    logic [POS_W-1:0]    deleted_count;
    logic [POS_W-1:0]    text_length;
    logic [1:0]          status;

    modport source (output valid, output char_out, output deleted_count,
                    output text_length, output status, input ready);
    modport sink   (input valid, input char_out, input deleted_count,
                    input text_length, input status, output ready);
endinterface

// File: design/gbts_ctrl.sv
module gbts_ctrl
    import gbts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.judge = 1'b1;
                if (stat.check_fail)
                begin
                    state_next = S_DONE;
                end
                else if (stat.is_read)
                begin
                    cmd.read_rd = 1'b1;
                    state_next  = S_READ_WAIT;
                end
                else
                begin
                    state_next = S_MOVE_RD;
                end
            end
            S_MOVE_RD:
            begin
                if (stat.move_left || stat.move_right)
                begin
                    cmd.move_rd = 1'b1;
                    state_next  = S_MOVE_WR;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_MOVE_RD;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_DONE;
            end
            S_READ_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // every shift write follows the read that fetched its character
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE_WR |-> $past(state_reg) == S_MOVE_RD)
        else $error("gap shift write without preceding read");

    // a result is only produced after an item was checked
    a_done_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_DONE) |-> ($past(state_reg) == S_CHECK
            || $past(state_reg) == S_APPLY || $past(state_reg) == S_READ_WAIT))
        else $error("result stage entered from unexpected state");
`endif

endmodule

// File: design/gbts_dp.sv
module gbts_dp
    import gbts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [1:0]          in_kind,
    input  logic [POS_W-1:0]    in_position,
    input  logic [POS_W-1:0]    in_range_end,
    input  logic [CHAR_W-1:0]   in_char,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [CHAR_W-1:0]   out_char,
    output logic [POS_W-1:0]    out_deleted,
    output logic [POS_W-1:0]    out_length,
    output logic [1:0]          out_status
);

    // character store
    logic [CHAR_W-1:0] mem [CAPACITY];
    logic [CHAR_W-1:0] rdata_reg;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;

    // captured request
    logic [1:0]        kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  rend_reg;
    logic [CHAR_W-1:0] ch_reg;

    // gap bookkeeping
    logic [POS_W-1:0]  gap_first_reg, gap_first_next;
    logic [POS_W-1:0]  gap_after_reg, gap_after_next;
    logic [POS_W-1:0]  length_reg, length_next;
    logic [ADDR_W-1:0] dst_reg;

    status_t           st_reg;
    status_t           st_next;
    logic              hit_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_out_reg;
    logic [POS_W-1:0]  deleted_reg;
    logic [POS_W-1:0]  text_length_reg;
    status_t           status_reg;

    logic              bad;
    logic              full;
    logic              move_left;
    logic [POS_W-1:0]  gap_size;
    logic [POS_W:0]    read_sum;
    logic [ADDR_W-1:0] read_idx;
    logic [POS_W-1:0]  gap_first_m1;
    logic [POS_W-1:0]  gap_after_m1;
    logic [POS_W-1:0]  del_count;
    logic              is_insert;

    assign is_insert    = kind_reg == KIND_INSERT;
    assign move_left    = gap_first_reg > pos_reg;
    assign gap_size     = gap_after_reg - gap_first_reg;
    assign read_sum     = {1'b0, pos_reg} + {1'b0, gap_size};
    assign read_idx     = (pos_reg >= gap_first_reg) ? read_sum[ADDR_W-1:0]
                                                     : pos_reg[ADDR_W-1:0];
    assign gap_first_m1 = gap_first_reg - 1'b1;
    assign gap_after_m1 = gap_after_reg - 1'b1;
    assign del_count    = rend_reg - pos_reg;

    // request checks
    always_comb
    begin
        bad  = 1'b0;
        full = 1'b0;
        priority if (kind_reg == KIND_INSERT)
        begin
            bad  = pos_reg > length_reg;
            full = length_reg == CAP_LEN;
        end
        else if (kind_reg == KIND_DELETE)
        begin
            bad = (pos_reg > rend_reg) || (rend_reg > length_reg);
        end
        else if (kind_reg == KIND_READ)
        begin
            bad = pos_reg > length_reg;
        end
        else
        begin
            bad = 1'b1;
        end
    end

    always_comb
    begin
        priority if (bad)
        begin
            st_next = ST_INVALID;
        end
        else if (full)
        begin
            st_next = ST_FULL;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    assign stat.check_fail = bad || full;
    assign stat.is_read    = kind_reg == KIND_READ;
    assign stat.move_left  = move_left;
    assign stat.move_right = gap_first_reg < pos_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // memory port control
    assign mem_re  = cmd.read_rd || cmd.move_rd;
    assign rd_addr = cmd.read_rd ? read_idx
                   : (move_left ? gap_first_m1[ADDR_W-1:0] : gap_after_reg[ADDR_W-1:0]);
    assign mem_we  = cmd.move_wr || (cmd.apply && is_insert);
    assign wr_addr = cmd.move_wr ? dst_reg : gap_first_reg[ADDR_W-1:0];
    assign wr_data = cmd.move_wr ? rdata_reg : ch_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // request capture and per-item flags
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= in_kind;
            pos_reg  <= in_position;
            rend_reg <= in_range_end;
            ch_reg   <= in_char;
        end
        if (cmd.judge)
        begin
            st_reg  <= st_next;
            hit_reg <= (kind_reg == KIND_READ) && (pos_reg < length_reg);
        end
        if (cmd.move_rd)
        begin
            dst_reg <= move_left ? gap_after_m1[ADDR_W-1:0] : gap_first_reg[ADDR_W-1:0];
        end
    end

    // gap pointer updates
    always_comb
    begin
        gap_first_next = gap_first_reg;
        gap_after_next = gap_after_reg;
        length_next    = length_reg;
        if (cmd.move_rd)
        begin
            if (move_left)
            begin
                gap_first_next = gap_first_m1;
                gap_after_next = gap_after_m1;
            end
            else
            begin
                gap_first_next = gap_first_reg + 1'b1;
                gap_after_next = gap_after_reg + 1'b1;
            end
        end
        else if (cmd.apply)
        begin
            if (is_insert)
            begin
                gap_first_next = gap_first_reg + 1'b1;
                length_next    = length_reg + 1'b1;
            end
            else
            begin
                gap_after_next = gap_after_reg + del_count;
                length_next    = length_reg - del_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_first_reg <= '0;
            gap_after_reg <= CAP_LEN;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gap_first_reg <= gap_first_next;
            gap_after_reg <= gap_after_next;
            length_reg    <= length_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            char_out_reg    <= hit_reg ? rdata_reg : '0;
            deleted_reg     <= (kind_reg == KIND_DELETE && st_reg == ST_OK) ? del_count : '0;
            text_length_reg <= length_reg;
            status_reg      <= st_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = char_out_reg;
    assign out_deleted = deleted_reg;
    assign out_length  = text_length_reg;
    assign out_status  = status_reg;

`ifndef ASSERT_OFF
    // gap size always matches the free space
    a_gap_invariant: assert property (@(posedge clk) disable iff (!rst_n)
        gap_after_reg - gap_first_reg == CAP_LEN - length_reg)
        else $error("gap size disagrees with text length");

    // gap never inverted and never past the end of the store
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        gap_first_reg <= gap_after_reg && gap_after_reg <= CAP_LEN)
        else $error("gap pointers out of order");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while pending");

    // insert writes land inside the gap
    a_insert_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && is_insert) |-> gap_first_reg < gap_after_reg)
        else $error("insert into a closed gap");
`endif

endmodule

// File: design/gap_buffer_text_store.sv
// gap buffer text store: holds up to CAPACITY (4096) 16-bit characters with a
// movable gap at the edit point. each request is an insert of one character,
// a delete of a position range, or a read of one character, and each request
// gives exactly one response carrying the character read, the count deleted,
// the text length after the request and a status (ok, full, invalid).
// operation: one request is handled at a time. a read does one memory read
// after the check; a rejected request goes straight from the check to the
// response register. for an insert or delete the gap first moves to the edit
// point, one memory read then one memory write per character it moves across
// (on the single read and single write port of the character memory), and the
// edit is then applied. the next request can be accepted in the cycle after the
// response loads. a response still waiting for its consumer holds the block at
// the result stage. edits near the previous one need few gap moves and are
// fast. the character memory is not cleared after reset; only written
// characters ever reach the response.
module gap_buffer_text_store
    import gbts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gbts_req_if.sink  req,
    gbts_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: accept, check, gap moves and apply or read, result
    gbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // character memory, gap pointers and the response register
    gbts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_kind      (req.kind),
        .in_position  (req.position),
        .in_range_end (req.range_end),
        .in_char      (req.char_in),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_char     (rsp.char_out),
        .out_deleted  (rsp.deleted_count),
        .out_length   (rsp.text_length),
        .out_status   (rsp.status)
    );

endmodule
